/* sv/szt_pkg.sv */
package szt_pkg;

   localparam int SAMPLE_BITS_DEF = 24;

   localparam int DELAY_W     = 16;
   localparam int RANGE_W     = 23;
   localparam int COUNT_W     = DELAY_W + 1;
   localparam int MODE_W      = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 23;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [MODE_W-1:0] MODE_SAMPLE    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SET_ZERO  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLR_ZERO  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RESERVED  = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_DELAY    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_RANGE    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HAND_RANGE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRACE_INTERVAL = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRACE_RANGE    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRACE_STEP     = 3'd5;

   localparam int KIND_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_SAMPLE,
      KIND_SET,
      KIND_CLEAR
   } kind_type;

   typedef struct packed {
      logic [DELAY_W-1:0] power_delay;
      logic [RANGE_W-1:0] power_range;
      logic [RANGE_W-1:0] hand_range;
      logic [DELAY_W-1:0] trace_interval;
      logic [RANGE_W-1:0] trace_range;
      logic [RANGE_W-1:0] trace_step;
   } cfg_type;

endpackage

/* sv/szt_front.sv */
module szt_front import szt_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [MODE_W-1:0]             req_mode,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output cfg_type                       cfg,
   output logic                          push_valid,
   input  logic                          push_ready,
   output kind_type                      push_kind,
   output logic signed [SAMPLE_BITS-1:0] push_sample
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_POWER_DELAY:    cfg_in.power_delay    = csr_data[DELAY_W-1:0];
            CSR_POWER_RANGE:    cfg_in.power_range    = csr_data[RANGE_W-1:0];
            CSR_HAND_RANGE:     cfg_in.hand_range     = csr_data[RANGE_W-1:0];
            CSR_TRACE_INTERVAL: cfg_in.trace_interval = csr_data[DELAY_W-1:0];
            CSR_TRACE_RANGE:    cfg_in.trace_range    = csr_data[RANGE_W-1:0];
            CSR_TRACE_STEP:     cfg_in.trace_step     = csr_data[RANGE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // accept reserved mode too, but drop it here
   assign req_tready  = push_ready;
   assign push_valid  = req_tvalid && (req_mode != MODE_RESERVED);
   assign push_sample = req_sample;

   always_comb begin
      unique case (req_mode)
         MODE_SAMPLE:   push_kind = KIND_SAMPLE;
         MODE_SET_ZERO: push_kind = KIND_SET;
         MODE_CLR_ZERO: push_kind = KIND_CLEAR;
         default:       push_kind = KIND_SAMPLE;
      endcase
   end

endmodule

/* sv/szt_queue.sv */
module szt_queue import szt_pkg::*; #(
   parameter int DATA_W = KIND_W + SAMPLE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

/* sv/szt_back.sv */
module szt_back import szt_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          head_valid,
   input  kind_type                      head_kind,
   input  logic signed [SAMPLE_BITS-1:0] head_sample,
   output logic                          head_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS:0]   rsp_net
);

   localparam int SB = SAMPLE_BITS;
   localparam int CW = (SB + 1 > RANGE_W) ? SB + 1 : RANGE_W;

   typedef enum logic [1:0] {
      PEND_NONE,
      PEND_SET,
      PEND_CLEAR
   } pend_type;

   typedef logic signed [SB-1:0] smp_type;

   logic [COUNT_W-1:0] power_count_ff, power_count_in;
   smp_type            power_zero_ff, power_zero_in;
   smp_type            tracked_zero_ff, tracked_zero_in;
   smp_type            point_old_ff, point_old_in;
   smp_type            point_mid_ff, point_mid_in;
   smp_type            point_new_ff, point_new_in;
   pend_type           pending_ff, pending_in;
   logic [DELAY_W-1:0] trace_count_ff, trace_count_in;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_force_ff, s1_force_in;
   smp_type            s1_sample_ff, s1_sample_in;
   smp_type            s1_zero_ff, s1_zero_in;
   logic               out_valid_ff, out_valid_in;
   logic signed [SB:0] out_net_ff, out_net_in;

   logic               advance;
   smp_type            trace_keep, trace_set, trace_clr;

   function automatic logic [CW-1:0] mag_diff(input smp_type a, input smp_type b);
      logic signed [SB:0] d;
      logic [SB:0]        m;
      d = (SB+1)'(a) - (SB+1)'(b);
      m = d[SB] ? (~d + 1'b1) : d;
      return CW'(m);
   endfunction

   function automatic logic near3(input smp_type po, input smp_type pm, input smp_type pn,
                                  input smp_type z, input logic [RANGE_W-1:0] r);
      return (mag_diff(po, z) < CW'(r)) && (mag_diff(pm, z) < CW'(r)) &&
             (mag_diff(pn, z) < CW'(r));
   endfunction

   // zero after a tracking check, for one choice of tracked and power-on zero
   function automatic smp_type trace_next(input smp_type z, input smp_type pz,
                                          input smp_type po, input smp_type pm,
                                          input smp_type pn,
                                          input logic [RANGE_W-1:0] r,
                                          input logic [RANGE_W-1:0] st);
      logic signed [CW:0] up, dn;
      up = (CW+1)'(z) + $signed({1'b0, CW'(st)});
      dn = (CW+1)'(z) - $signed({1'b0, CW'(st)});
      if (near3(po, pm, pn, z, r)) begin
         if (mag_diff(pm, z) <= CW'(st)) begin
            return pm;
         end else if (pm > z) begin
            return up[SB-1:0];
         end
         return dn[SB-1:0];
      end else if (near3(po, pm, pn, pz, r)) begin
         return pz;
      end
      return z;
   endfunction

   // points after the shift: middle becomes oldest, newest becomes middle
   assign trace_keep = trace_next(tracked_zero_ff, power_zero_ff, point_mid_ff, point_new_ff,
                                  head_sample, cfg.trace_range, cfg.trace_step);
   assign trace_set  = trace_next(head_sample, head_sample, point_mid_ff, point_new_ff,
                                  head_sample, cfg.trace_range, cfg.trace_step);
   assign trace_clr  = trace_next('0, '0, point_mid_ff, point_new_ff,
                                  head_sample, cfg.trace_range, cfg.trace_step);

   assign advance   = !out_valid_ff || rsp_ready;
   assign head_pop  = head_valid && advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_net   = out_net_ff;

   always_comb begin
      logic               set_ok;
      logic               use_set, use_clr;
      logic [DELAY_W-1:0] cnt_next;

      power_count_in  = power_count_ff;
      power_zero_in   = power_zero_ff;
      tracked_zero_in = tracked_zero_ff;
      point_old_in    = point_old_ff;
      point_mid_in    = point_mid_ff;
      point_new_in    = point_new_ff;
      pending_in      = pending_ff;
      trace_count_in  = trace_count_ff;
      s1_valid_in     = s1_valid_ff;
      s1_force_in     = s1_force_ff;
      s1_sample_in    = s1_sample_ff;
      s1_zero_in      = s1_zero_ff;
      out_valid_in    = out_valid_ff;
      out_net_in      = out_net_ff;

      set_ok   = mag_diff(head_sample, tracked_zero_ff) <= CW'(cfg.hand_range);
      use_set  = (pending_ff == PEND_SET) && set_ok;
      use_clr  = (pending_ff == PEND_CLEAR);
      cnt_next = trace_count_ff + 1'b1;

      if (advance) begin
         out_valid_in = s1_valid_ff;
         out_net_in   = s1_force_ff ? '0 : ((SB+1)'(s1_sample_ff) - (SB+1)'(s1_zero_ff));
         s1_valid_in  = 1'b0;
      end

      if (head_pop) begin
         unique case (head_kind)
            KIND_SET: begin
               pending_in = PEND_SET;
            end
            KIND_CLEAR: begin
               pending_in = PEND_CLEAR;
            end
            KIND_SAMPLE: begin
               s1_valid_in  = 1'b1;
               s1_force_in  = 1'b0;
               s1_sample_in = head_sample;
               if (power_count_ff < COUNT_W'(cfg.power_delay)) begin
                  power_count_in = power_count_ff + 1'b1;
                  s1_force_in    = 1'b1;
               end else if (power_count_ff == COUNT_W'(cfg.power_delay)) begin
                  if (mag_diff(head_sample, '0) <= CW'(cfg.power_range)) begin
                     power_zero_in   = head_sample;
                     tracked_zero_in = head_sample;
                  end
                  point_old_in   = head_sample;
                  point_mid_in   = head_sample;
                  point_new_in   = head_sample;
                  power_count_in = power_count_ff + 1'b1;
                  pending_in     = PEND_NONE;
                  trace_count_in = '0;
               end else begin
                  pending_in = PEND_NONE;
                  if (use_set) begin
                     power_zero_in   = head_sample;
                     tracked_zero_in = head_sample;
                  end else if (use_clr) begin
                     power_zero_in   = '0;
                     tracked_zero_in = '0;
                  end
                  if (cfg.trace_interval == '0) begin
                     trace_count_in = '0;
                  end else if (cnt_next < cfg.trace_interval) begin
                     trace_count_in = cnt_next;
                  end else begin
                     trace_count_in = '0;
                     point_old_in   = point_mid_ff;
                     point_mid_in   = point_new_ff;
                     point_new_in   = head_sample;
                     priority if (use_set) begin
                        tracked_zero_in = trace_set;
                     end else if (use_clr) begin
                        tracked_zero_in = trace_clr;
                     end else begin
                        tracked_zero_in = trace_keep;
                     end
                  end
               end
               s1_zero_in = tracked_zero_in;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_count_ff  <= '0;
         power_zero_ff   <= '0;
         tracked_zero_ff <= '0;
         point_old_ff    <= '0;
         point_mid_ff    <= '0;
         point_new_ff    <= '0;
         pending_ff      <= PEND_NONE;
         trace_count_ff  <= '0;
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         power_count_ff  <= power_count_in;
         power_zero_ff   <= power_zero_in;
         tracked_zero_ff <= tracked_zero_in;
         point_old_ff    <= point_old_in;
         point_mid_ff    <= point_mid_in;
         point_new_ff    <= point_new_in;
         pending_ff      <= pending_in;
         trace_count_ff  <= trace_count_in;
         s1_valid_ff     <= s1_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_force_ff  <= s1_force_in;
      s1_sample_ff <= s1_sample_in;
      s1_zero_ff   <= s1_zero_in;
      out_net_ff   <= out_net_in;
   end

endmodule

/* sv/scale_zero_tracker_top.sv */
// Zero tracker for a weighing scale. Each sample request (tuser mode sample) yields one
// net weight, the sample minus the tracked zero, or zero while the power-on delay runs;
// set-zero and clear-zero requests yield nothing and act on the next sample. The block
// takes one request per clock and returns one result per clock while the result side
// keeps up; a result passes from the queue into the zero-update stage register and from
// there into the output register. That rate is set by the zero-update stage, which
// resolves the pending request and the tracking check of a sample as it is popped. A
// two-entry queue sits between the request decode and that stage, so up to two more
// requests are taken after the result side stalls.
// Write the registers only while no requests are in flight.
module scale_zero_tracker_top import szt_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [CSR_INDEX_W-1:0]                 csr_index,
   input  logic [CSR_DATA_W-1:0]                  csr_data,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       req_tdata,  // sample
   input  logic [MODE_W-1:0]                      req_tuser,  // mode
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((SAMPLE_BITS+1+7)/8)*8-1:0]     rsp_tdata   // net_weight
);

   localparam int OUT_W  = ((SAMPLE_BITS + 1 + 7) / 8) * 8;
   localparam int DATA_W = KIND_W + SAMPLE_BITS;

   cfg_type                       cfg;
   logic                          push_valid, push_ready;
   kind_type                      push_kind;
   logic signed [SAMPLE_BITS-1:0] push_sample;
   logic                          pop_valid, pop;
   logic [DATA_W-1:0]             pop_data;
   logic signed [SAMPLE_BITS:0]   net_weight;

   szt_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_mode    (req_tuser),
      .req_sample  ($signed(req_tdata[SAMPLE_BITS-1:0])),
      .cfg         (cfg),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_kind   (push_kind),
      .push_sample (push_sample)
   );

   szt_queue #(.DATA_W(DATA_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_kind, push_sample}),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_data)
   );

   szt_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .head_valid  (pop_valid),
      .head_kind   (kind_type'(pop_data[DATA_W-1:SAMPLE_BITS])),
      .head_sample ($signed(pop_data[SAMPLE_BITS-1:0])),
      .head_pop    (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_net     (net_weight)
   );

   assign rsp_tdata = OUT_W'($unsigned(net_weight));

endmodule

/* sv/szt_checker.sv */
module szt_checker import szt_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [((SAMPLE_BITS+1+7)/8)*8-1:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed or dropped while stalled");

   // reset empties the pipeline
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // reset empties the queue, so requests are taken at once
   a_req_reset: assert property (@(posedge clock)
      $past(reset) |-> req_tready)
      else $error("request side not ready right after reset");

   // bits above the net weight stay clear
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata >> (SAMPLE_BITS + 1)) == '0))
      else $error("padding bits set in result");

endmodule

bind scale_zero_tracker_top szt_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_szt_checker (.*);
